// ===== rtl/lfpd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line follower PID drive: shared package
// Widths, register map, reset values, command and status structures, and the
// sensor pattern to steering error table.
// ----------------------------------------------------------------------------
package lfpd_pkg;

   localparam int SENS_W           = 5;
   localparam int REQ_TDATA_W      = 8;
   localparam int MAG_W            = 16;
   localparam int IDLE_W           = 8;
   localparam int RSP_FIELDS_W     = 2 * MAG_W + 3 + IDLE_W;
   localparam int RSP_TDATA_W      = 48;
   localparam int RSP_TUSER_W      = 1;
   localparam int GAIN_W           = 24;
   localparam int SPEED_W          = 8;
   localparam int CSR_ADDR_W       = 3;
   localparam int CSR_DATA_W       = 24;
   localparam int ERR_W            = 13;
   localparam int ERR_MAX          = 2000;
   localparam int Q_SHIFT          = 16;
   localparam int HISTORY_TAPS_DEF = 5;

   localparam logic [GAIN_W-1:0]  GAIN_P_RST = GAIN_W'(131);
   localparam logic [GAIN_W-1:0]  GAIN_I_RST = GAIN_W'(66);
   localparam logic [GAIN_W-1:0]  GAIN_D_RST = GAIN_W'(983040);
   localparam logic [GAIN_W-1:0]  GAIN_R_RST = GAIN_W'(0);
   localparam logic [SPEED_W-1:0] BASE_RST   = SPEED_W'(142);
   localparam logic [SPEED_W-1:0] MAX_RST    = SPEED_W'(150);
   localparam logic [IDLE_W-1:0]  IDLE_MAX   = '1;

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_GAIN_P,
      REG_GAIN_I,
      REG_GAIN_D,
      REG_GAIN_R,
      REG_BASE_RIGHT,
      REG_BASE_LEFT,
      REG_MAX_RIGHT,
      REG_MAX_LEFT
   } reg_idx_type;

   typedef struct packed {
      logic [GAIN_W-1:0]  gain_p;
      logic [GAIN_W-1:0]  gain_i;
      logic [GAIN_W-1:0]  gain_d;
      logic [GAIN_W-1:0]  gain_r;
      logic [SPEED_W-1:0] base_right;
      logic [SPEED_W-1:0] base_left;
      logic [SPEED_W-1:0] max_right;
      logic [SPEED_W-1:0] max_left;
   } cfg_type;

   typedef enum logic [1:0] {
      MUL_ERR,
      MUL_ISUM,
      MUL_DERR,
      MUL_RSUM
   } mul_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_ADD
   } acc_op_type;

   typedef struct packed {
      logic        update;
      logic        mul_en;
      mul_sel_type mul_sel;
      acc_op_type  acc_op;
      logic        drive_en;
      logic        num_en;
      logic        speed_en;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      logic lost;
      logic out_free;
   } status_type;

   // Error is 3000 minus the truncated mean of the active sensor weights.
   function automatic logic signed [ERR_W-1:0] lfpd_err_of(input logic [SENS_W-1:0] s);
      logic signed [ERR_W-1:0] e;
      case (s)
         5'd1:    e = ERR_W'(2000);
         5'd2:    e = ERR_W'(1000);
         5'd3:    e = ERR_W'(1500);
         5'd4:    e = ERR_W'(0);
         5'd5:    e = ERR_W'(1000);
         5'd6:    e = ERR_W'(500);
         5'd7:    e = ERR_W'(1000);
         5'd8:    e = ERR_W'(-1000);
         5'd9:    e = ERR_W'(500);
         5'd10:   e = ERR_W'(0);
         5'd11:   e = ERR_W'(667);
         5'd12:   e = ERR_W'(-500);
         5'd13:   e = ERR_W'(334);
         5'd14:   e = ERR_W'(0);
         5'd15:   e = ERR_W'(500);
         5'd16:   e = ERR_W'(-2000);
         5'd17:   e = ERR_W'(0);
         5'd18:   e = ERR_W'(-500);
         5'd19:   e = ERR_W'(334);
         5'd20:   e = ERR_W'(-1000);
         5'd21:   e = ERR_W'(0);
         5'd22:   e = ERR_W'(-333);
         5'd23:   e = ERR_W'(250);
         5'd24:   e = ERR_W'(-1500);
         5'd25:   e = ERR_W'(-333);
         5'd26:   e = ERR_W'(-666);
         5'd27:   e = ERR_W'(0);
         5'd28:   e = ERR_W'(-1000);
         5'd29:   e = ERR_W'(-250);
         5'd30:   e = ERR_W'(-500);
         5'd31:   e = ERR_W'(0);
         default: e = '0;
      endcase
      return e;
   endfunction

endpackage

// ===== rtl/lfpd_csr.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line follower PID drive: configuration registers
// Write-only register file for gains and speed limits.
// ----------------------------------------------------------------------------
module lfpd_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [lfpd_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [lfpd_pkg::CSR_DATA_W-1:0] csr_wdata,
   output lfpd_pkg::cfg_type              cfg
);
   import lfpd_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (reg_idx_type'(csr_addr))
            REG_GAIN_P:     cfg_in.gain_p     = csr_wdata[GAIN_W-1:0];
            REG_GAIN_I:     cfg_in.gain_i     = csr_wdata[GAIN_W-1:0];
            REG_GAIN_D:     cfg_in.gain_d     = csr_wdata[GAIN_W-1:0];
            REG_GAIN_R:     cfg_in.gain_r     = csr_wdata[GAIN_W-1:0];
            REG_BASE_RIGHT: cfg_in.base_right = csr_wdata[SPEED_W-1:0];
            REG_BASE_LEFT:  cfg_in.base_left  = csr_wdata[SPEED_W-1:0];
            REG_MAX_RIGHT:  cfg_in.max_right  = csr_wdata[SPEED_W-1:0];
            REG_MAX_LEFT:   cfg_in.max_left   = csr_wdata[SPEED_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_p     <= GAIN_P_RST;
         cfg_ff.gain_i     <= GAIN_I_RST;
         cfg_ff.gain_d     <= GAIN_D_RST;
         cfg_ff.gain_r     <= GAIN_R_RST;
         cfg_ff.base_right <= BASE_RST;
         cfg_ff.base_left  <= BASE_RST;
         cfg_ff.max_right  <= MAX_RST;
         cfg_ff.max_left   <= MAX_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/lfpd_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line follower PID drive: controller
// Sequences the shared multiplier, the speed steps and the result load.
// ----------------------------------------------------------------------------
module lfpd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  lfpd_pkg::status_type status,
   output lfpd_pkg::cmd_type    cmd
);
   import lfpd_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_P,
      ST_MUL_I,
      ST_MUL_D,
      ST_MUL_R,
      ST_DRIVE,
      ST_SPEED,
      ST_CLAMP,
      ST_OUTPUT
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.update = accept;
            if (accept) begin
               // A sample with no active sensor skips the arithmetic.
               state_in = status.lost ? ST_OUTPUT : ST_MUL_P;
            end
         end
         ST_MUL_P: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_ERR;
            state_in    = ST_MUL_I;
         end
         ST_MUL_I: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_ISUM;
            cmd.acc_op  = ACC_LOAD;
            state_in    = ST_MUL_D;
         end
         ST_MUL_D: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_DERR;
            cmd.acc_op  = ACC_ADD;
            state_in    = ST_MUL_R;
         end
         ST_MUL_R: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_RSUM;
            cmd.acc_op  = ACC_ADD;
            state_in    = ST_DRIVE;
         end
         ST_DRIVE: begin
            cmd.drive_en = 1'b1;
            state_in     = ST_SPEED;
         end
         ST_SPEED: begin
            cmd.num_en = 1'b1;
            state_in   = ST_CLAMP;
         end
         ST_CLAMP: begin
            cmd.speed_en = 1'b1;
            state_in     = ST_OUTPUT;
         end
         ST_OUTPUT: begin
            cmd.out_load = status.out_free;
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/lfpd_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line follower PID drive: datapath
// Error history, running sums, shared multiplier, speed math and result
// register.
// ----------------------------------------------------------------------------
module lfpd_dp #(
   parameter int HISTORY_TAPS = lfpd_pkg::HISTORY_TAPS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  lfpd_pkg::cfg_type                cfg,
   input  lfpd_pkg::cmd_type                cmd,
   output lfpd_pkg::status_type             status,
   input  logic [lfpd_pkg::REQ_TDATA_W-1:0] req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [lfpd_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic [lfpd_pkg::RSP_TUSER_W-1:0] rsp_tuser
);
   import lfpd_pkg::*;

   localparam int HSUM_MAX = HISTORY_TAPS * ERR_MAX;
   localparam int RSUM_W   = $clog2(HSUM_MAX + 1);
   localparam int ISUM_W   = RSUM_W + 1;
   localparam int DERR_W   = ERR_W + 1;
   localparam int MUL_A_W  = (ISUM_W > DERR_W) ? ISUM_W : DERR_W;
   localparam int MUL_B_W  = GAIN_W + 1;
   localparam int PROD_W   = MUL_A_W + MUL_B_W;
   localparam int ACC_W    = PROD_W + 2;
   localparam int DRV_W    = ACC_W - Q_SHIFT;
   localparam int NUM_W    = ACC_W + 2;
   localparam int SPD_W    = NUM_W - Q_SHIFT;
   localparam int PAD_W    = RSP_TDATA_W - RSP_FIELDS_W;

   logic [SENS_W-1:0]        sens;
   logic signed [ERR_W-1:0]  err_new;
   logic signed [ERR_W-1:0]  err_neg;
   logic [ERR_W-2:0]         err_abs;
   logic signed [ERR_W-1:0]  oldest;
   logic signed [ERR_W-1:0]  old_neg;
   logic [ERR_W-2:0]         old_abs;

   logic signed [ERR_W-1:0]  hist_ff [HISTORY_TAPS];
   logic signed [ISUM_W-1:0] isum_ff;
   logic signed [ISUM_W-1:0] isum_in;
   logic [RSUM_W-1:0]        rsum_ff;
   logic [RSUM_W-1:0]        rsum_in;
   logic signed [ERR_W-1:0]  prev_ff;
   logic signed [ERR_W-1:0]  err_ff;
   logic signed [DERR_W-1:0] derr_ff;
   logic signed [DERR_W-1:0] derr_in;
   logic                     side_ff;
   logic                     side_in;
   logic [IDLE_W-1:0]        idle_ff;
   logic [IDLE_W-1:0]        idle_in;
   logic                     valid_ff;

   logic signed [MUL_A_W-1:0] mul_a;
   logic [GAIN_W-1:0]         gain_sel;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  prod_in;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [ACC_W-1:0]   acc_in;
   logic signed [ACC_W-1:0]   acc_ff;
   logic signed [ACC_W-1:0]   acc_adj;
   logic signed [DRV_W-1:0]   drive_ff;

   logic signed [NUM_W-1:0]   base_l_x;
   logic signed [NUM_W-1:0]   base_r_x;
   logic signed [NUM_W-1:0]   drv_x;
   logic signed [NUM_W-1:0]   sum_l;
   logic signed [NUM_W-1:0]   sum_r;
   logic signed [NUM_W-1:0]   num_l_in;
   logic signed [NUM_W-1:0]   num_r_in;
   logic signed [NUM_W-1:0]   num_l_ff;
   logic signed [NUM_W-1:0]   num_r_ff;
   logic signed [NUM_W-1:0]   adj_l;
   logic signed [NUM_W-1:0]   adj_r;
   logic signed [SPD_W-1:0]   trunc_l;
   logic signed [SPD_W-1:0]   trunc_r;
   logic signed [SPD_W-1:0]   max_l_x;
   logic signed [SPD_W-1:0]   max_r_x;
   logic signed [SPD_W-1:0]   spd_l_ff;
   logic signed [SPD_W-1:0]   spd_r_ff;
   logic signed [SPD_W-1:0]   abs_l;
   logic signed [SPD_W-1:0]   abs_r;
   logic [MAG_W-1:0]          mag_l;
   logic [MAG_W-1:0]          mag_r;

   logic                      rsp_tvalid_ff;
   logic [RSP_TDATA_W-1:0]    rsp_tdata_ff;
   logic [RSP_TUSER_W-1:0]    rsp_tuser_ff;
   logic [RSP_TDATA_W-1:0]    tdata_in;

   // Sample decode and history update.
   assign sens    = req_tdata[SENS_W-1:0];
   assign err_new = lfpd_err_of(sens);
   assign err_neg = -err_new;
   assign err_abs = err_new[ERR_W-1] ? err_neg[ERR_W-2:0] : err_new[ERR_W-2:0];
   assign oldest  = hist_ff[HISTORY_TAPS-1];
   assign old_neg = -oldest;
   assign old_abs = oldest[ERR_W-1] ? old_neg[ERR_W-2:0] : oldest[ERR_W-2:0];

   // The sums track the history as the oldest error leaves and the new one enters.
   assign isum_in = isum_ff + ISUM_W'(err_new) - ISUM_W'(oldest);
   assign rsum_in = rsum_ff + RSUM_W'(err_abs) - RSUM_W'(old_abs);
   assign derr_in = DERR_W'(err_new) - DERR_W'(prev_ff);

   always_comb begin
      side_in = side_ff;
      if (sens[0]) begin
         side_in = 1'b1;
      end
      if (sens[SENS_W-1]) begin
         side_in = 1'b0;
      end
      if (sens == '0) begin
         idle_in = (idle_ff == IDLE_MAX) ? idle_ff : idle_ff + IDLE_W'(1);
      end else begin
         idle_in = '0;
      end
   end

   assign status.lost     = (sens == '0);
   assign status.out_free = !rsp_tvalid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < HISTORY_TAPS; k++) begin
            hist_ff[k] <= '0;
         end
         isum_ff <= '0;
         rsum_ff <= '0;
         prev_ff <= '0;
         side_ff <= 1'b0;
         idle_ff <= '0;
      end else if (cmd.update) begin
         side_ff <= side_in;
         idle_ff <= idle_in;
         if (sens != '0) begin
            for (int k = HISTORY_TAPS - 1; k > 0; k--) begin
               hist_ff[k] <= hist_ff[k-1];
            end
            hist_ff[0] <= err_new;
            isum_ff    <= isum_in;
            rsum_ff    <= rsum_in;
            prev_ff    <= err_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         valid_ff <= (sens != '0);
         err_ff   <= err_new;
         derr_ff  <= derr_in;
      end
   end

   // Shared multiplier: one term per cycle, accumulated in the following cycle.
   always_comb begin
      case (cmd.mul_sel)
         MUL_ERR: begin
            mul_a    = MUL_A_W'(err_ff);
            gain_sel = cfg.gain_p;
         end
         MUL_ISUM: begin
            mul_a    = MUL_A_W'(isum_ff);
            gain_sel = cfg.gain_i;
         end
         MUL_DERR: begin
            mul_a    = MUL_A_W'(derr_ff);
            gain_sel = cfg.gain_d;
         end
         MUL_RSUM: begin
            mul_a    = MUL_A_W'($signed({1'b0, rsum_ff}));
            gain_sel = cfg.gain_r;
         end
         default: begin
            mul_a    = '0;
            gain_sel = '0;
         end
      endcase
   end

   assign mul_b   = $signed({1'b0, gain_sel});
   assign prod_in = mul_a * mul_b;

   always_comb begin
      case (cmd.acc_op)
         ACC_LOAD: acc_in = ACC_W'(prod_ff);
         ACC_ADD:  acc_in = acc_ff + ACC_W'(prod_ff);
         default:  acc_in = acc_ff;
      endcase
   end

   // Adding 2^16-1 to a negative value before the shift truncates toward zero.
   assign acc_adj = acc_ff + $signed({{(ACC_W-Q_SHIFT){1'b0}}, {Q_SHIFT{acc_ff[ACC_W-1]}}});

   assign base_l_x = $signed({{(NUM_W-SPEED_W){1'b0}}, cfg.base_left});
   assign base_r_x = $signed({{(NUM_W-SPEED_W){1'b0}}, cfg.base_right});
   assign drv_x    = NUM_W'(drive_ff);
   assign sum_l    = base_l_x + drv_x;
   assign sum_r    = base_r_x - drv_x;
   assign num_l_in = (sum_l <<< Q_SHIFT) - NUM_W'(prod_ff);
   assign num_r_in = (sum_r <<< Q_SHIFT) - NUM_W'(prod_ff);

   assign adj_l   = num_l_ff + $signed({{(NUM_W-Q_SHIFT){1'b0}}, {Q_SHIFT{num_l_ff[NUM_W-1]}}});
   assign adj_r   = num_r_ff + $signed({{(NUM_W-Q_SHIFT){1'b0}}, {Q_SHIFT{num_r_ff[NUM_W-1]}}});
   assign trunc_l = adj_l[NUM_W-1:Q_SHIFT];
   assign trunc_r = adj_r[NUM_W-1:Q_SHIFT];
   assign max_l_x = $signed({{(SPD_W-SPEED_W){1'b0}}, cfg.max_left});
   assign max_r_x = $signed({{(SPD_W-SPEED_W){1'b0}}, cfg.max_right});

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
      end
      acc_ff <= acc_in;
      if (cmd.drive_en) begin
         drive_ff <= acc_adj[ACC_W-1:Q_SHIFT];
      end
      if (cmd.num_en) begin
         num_l_ff <= num_l_in;
         num_r_ff <= num_r_in;
      end
      if (cmd.speed_en) begin
         spd_l_ff <= (trunc_l > max_l_x) ? max_l_x : trunc_l;
         spd_r_ff <= (trunc_r > max_r_x) ? max_r_x : trunc_r;
      end
   end

   // Magnitude and direction, saturated to the field width.
   assign abs_l = spd_l_ff[SPD_W-1] ? -spd_l_ff : spd_l_ff;
   assign abs_r = spd_r_ff[SPD_W-1] ? -spd_r_ff : spd_r_ff;
   assign mag_l = (|abs_l[SPD_W-1:MAG_W]) ? '1 : abs_l[MAG_W-1:0];
   assign mag_r = (|abs_r[SPD_W-1:MAG_W]) ? '1 : abs_r[MAG_W-1:0];

   always_comb begin
      if (valid_ff) begin
         tdata_in = {{PAD_W{1'b0}}, idle_ff, side_ff,
                     !spd_l_ff[SPD_W-1], mag_l, !spd_r_ff[SPD_W-1], mag_r};
      end else begin
         tdata_in = {{PAD_W{1'b0}}, idle_ff, side_ff,
                     1'b1, {MAG_W{1'b0}}, 1'b1, {MAG_W{1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_tdata_ff <= tdata_in;
         rsp_tuser_ff <= RSP_TUSER_W'(valid_ff);
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

// ===== rtl/line_follower_pid_drive_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line follower PID drive: top level
// Turns five-sensor line samples into left and right motor commands.
// ----------------------------------------------------------------------------
// Usage:
// Each word on the req_ stream is one sensor sample. Each sample produces
// exactly one word on the rsp_ stream with the two motor commands, the side
// where the line was last seen and the count of consecutive samples without
// line. rsp_tuser is low when no sensor saw the line; that word carries zero
// speeds and leaves the error history untouched. Gains and speed limits are to
// be written on the csr_ port while idle; the block does not enforce it.
// A sample with line goes from acceptance to the result register through
// four passes through the single shared multiplier and the drive, speed and
// clamp steps; a sample without line goes straight to the result load.
// One sample is in work at a time, so req_tready stays low from acceptance
// until the result register is loaded.
// The result register lets the next sample be accepted while a result waits;
// a stalled rsp_ side holds the block in its final step.
// Reset clears the error history, side flag, idle count and restores the
// register defaults.
// ----------------------------------------------------------------------------
module line_follower_pid_drive_top #(
   parameter int HISTORY_TAPS = lfpd_pkg::HISTORY_TAPS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [4:0] sensors
   input  logic [lfpd_pkg::REQ_TDATA_W-1:0] req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [15:0] right_magnitude, [16] right_forward, [32:17] left_magnitude,
   // [33] left_forward, [34] last_side, [42:35] idle_count
   output logic [lfpd_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // [0] drive_valid
   output logic [lfpd_pkg::RSP_TUSER_W-1:0] rsp_tuser,
   input  logic                             csr_we,
   input  logic [lfpd_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [lfpd_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import lfpd_pkg::*;

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   lfpd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   lfpd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   lfpd_dp #(
      .HISTORY_TAPS (HISTORY_TAPS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== rtl/lfpd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line follower PID drive: port checker
// Watches the top-level ports for handshake and result consistency.
// ----------------------------------------------------------------------------
module lfpd_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [lfpd_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic [lfpd_pkg::RSP_TUSER_W-1:0] rsp_tuser
);
   import lfpd_pkg::*;

   // A stalled result word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result word changed while stalled");

   // Only one sample is in work at a time.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("sample accepted while another was in work");

   // A word without line carries zero speeds, forward, and a nonzero idle count.
   a_lost_word: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |->
         rsp_tdata[15:0] == '0 && rsp_tdata[16] &&
         rsp_tdata[32:17] == '0 && rsp_tdata[33] && rsp_tdata[42:35] != '0)
      else $error("lost-line word has wrong fields");

   // A drive command always comes with a cleared idle count.
   a_drive_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[42:35] == '0)
      else $error("drive word with nonzero idle count");

   // A zero right magnitude is always reported as forward.
   a_zero_fwd: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[15:0] == '0 |-> rsp_tdata[16])
      else $error("zero right speed reported as reverse");

endmodule

bind line_follower_pid_drive_top lfpd_checker u_lfpd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ===== tb/sv/tb_line_follower_pid_drive_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line follower PID drive: testbench
// Streams sensor samples through the drive block under several gain and speed
// settings and idle patterns. Every response word is compared field by field
// with a behavioral model of the steering loop kept inside this bench, or with the word given in the directed table.
// ----------------------------------------------------------------------------
module tb_line_follower_pid_drive_top;
   import lfpd_pkg::*;

   localparam int TAPS           = HISTORY_TAPS_DEF;
   localparam int MAX_RUN        = 16;
   localparam int SETTLE_CYCLES  = 12;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int NUM_PHASES     = 8;
   localparam int PHASE_ITEMS    = 150;
   localparam int LOST_RUN       = 260;

   typedef struct packed {
      logic             drive_valid;
      logic [MAG_W-1:0] right_mag;
      logic             right_fwd;
      logic [MAG_W-1:0] left_mag;
      logic             left_fwd;
      logic             last_side;
      logic [IDLE_W-1:0] idle_count;
   } drive_cmd_type;

   typedef struct packed {
      logic [REQ_TDATA_W-1:0] word;
      logic                   typed;
      drive_cmd_type          want;
   } sample_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [RSP_TUSER_W-1:0] rsp_tuser;
   logic                   csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_addr = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   line_follower_pid_drive_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Model state of the steering loop.
   cfg_type                 drive_cfg;
   logic signed [ERR_W-1:0] err_hist [TAPS];
   logic signed [ERR_W-1:0] prev_err;
   logic                    side_seen;
   logic [IDLE_W-1:0]       lost_samples;

   drive_cmd_type pending_cmds [$];
   int         error_count   = 0;
   int         send_idle_pct = 0;
   int         recv_stall_pct = 0;
   int         stall_run     = 0;
   int         quiet_cycles  = 0;
   int         line_pos      = 4;

   sample_row_type directed_rows [] = '{
      '{8'h00, 1'b1, {1'b0, 16'd0, 1'b1, 16'd0, 1'b1, 1'b0, 8'd1}},
      '{8'h00, 1'b1, {1'b0, 16'd0, 1'b1, 16'd0, 1'b1, 1'b0, 8'd2}},
      '{8'h04, 1'b1, {1'b1, 16'd142, 1'b1, 16'd142, 1'b1, 1'b0, 8'd0}},
      '{8'h01, 1'b0, '0}, '{8'h10, 1'b0, '0}, '{8'h11, 1'b0, '0},
      '{8'h1F, 1'b0, '0}, '{8'h03, 1'b0, '0}, '{8'h18, 1'b0, '0},
      '{8'h00, 1'b0, '0}, '{8'h01, 1'b0, '0}, '{8'h00, 1'b0, '0},
      '{8'h0E, 1'b0, '0}, '{8'h02, 1'b0, '0}, '{8'h08, 1'b0, '0},
      '{8'hE4, 1'b0, '0}, '{8'h15, 1'b0, '0}, '{8'h0A, 1'b0, '0},
      '{8'h1B, 1'b0, '0}, '{8'h0C, 1'b0, '0}, '{8'h06, 1'b0, '0},
      '{8'h1E, 1'b0, '0}, '{8'h0F, 1'b0, '0}
   };

   function automatic void split_speed(input longint spd, output logic [MAG_W-1:0] mag,
                                       output logic fwd);
      longint a;
      a   = (spd < 0) ? -spd : spd;
      fwd = (spd >= 0);
      mag = (a > 65535) ? 16'hFFFF : a[MAG_W-1:0];
   endfunction

   // Advances the loop state by one sample and returns the motor command.
   function automatic drive_cmd_type predict_drive(input logic [REQ_TDATA_W-1:0] word);
      logic [SENS_W-1:0]       s;
      int                      wsum;
      int                      active;
      logic signed [ERR_W-1:0] err;
      longint                  e, isum, rsum, drv, lnum, rnum, lspd, rspd;
      longint                  gp, gi, gd, gr, bl, br;
      drive_cmd_type           c;
      s      = word[SENS_W-1:0];
      wsum   = 0;
      active = 0;
      for (int k = 0; k < SENS_W; k++) begin
         if (s[k]) begin
            wsum += 1000 * (k + 1);
            active++;
         end
      end
      if (s[0]) side_seen = 1'b1;
      if (s[4]) side_seen = 1'b0;
      c = '0;
      if (active == 0) begin
         if (lost_samples != IDLE_MAX) lost_samples++;
         c.right_fwd  = 1'b1;
         c.left_fwd   = 1'b1;
         c.last_side  = side_seen;
         c.idle_count = lost_samples;
         return c;
      end
      lost_samples = '0;
      err = ERR_W'(3000 - wsum / active);
      for (int k = TAPS - 1; k > 0; k--) err_hist[k] = err_hist[k-1];
      err_hist[0] = err;
      isum = 0;
      rsum = 0;
      for (int k = 0; k < TAPS; k++) begin
         e = err_hist[k];
         isum += e;
         rsum += (e < 0) ? -e : e;
      end
      gp = drive_cfg.gain_p;
      gi = drive_cfg.gain_i;
      gd = drive_cfg.gain_d;
      gr = drive_cfg.gain_r;
      bl = drive_cfg.base_left;
      br = drive_cfg.base_right;
      e  = err;
      drv = (e * gp + isum * gi + (e - longint'(prev_err)) * gd) / 65536;
      prev_err = err;
      lnum = (bl + drv) * 65536 - rsum * gr;
      rnum = (br - drv) * 65536 - rsum * gr;
      lspd = lnum / 65536;
      rspd = rnum / 65536;
      if (lspd > longint'(drive_cfg.max_left)) lspd = drive_cfg.max_left;
      if (rspd > longint'(drive_cfg.max_right)) rspd = drive_cfg.max_right;
      c.drive_valid = 1'b1;
      split_speed(rspd, c.right_mag, c.right_fwd);
      split_speed(lspd, c.left_mag, c.left_fwd);
      c.last_side  = side_seen;
      c.idle_count = lost_samples;
      return c;
   endfunction

   // Mostly a line drifting across the array, with dropouts and noise mixed in.
   function automatic logic [REQ_TDATA_W-1:0] next_sample();
      logic [REQ_TDATA_W-1:0] word;
      int                     r;
      r = $urandom_range(99);
      if (r < 60) begin
         line_pos += $urandom_range(2) - 1;
         if (line_pos < 0) line_pos = 0;
         if (line_pos > 8) line_pos = 8;
         word = (line_pos % 2 == 0) ? (8'h01 << (line_pos / 2)) : (8'h03 << (line_pos / 2));
      end else if (r < 75) begin
         word = '0;
      end else begin
         word = 8'($urandom_range(31));
      end
      if ($urandom_range(9) == 0) word[7:5] = 3'($urandom_range(7));
      return word;
   endfunction

   task automatic report_error(input string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input longint got, input longint want);
      if (got != want)
         report_error($sformatf("%s got %0d expected %0d", name, got, want));
   endtask

   task automatic send_sample(input logic [REQ_TDATA_W-1:0] word, input logic typed,
                              input drive_cmd_type want);
      int            gap;
      drive_cmd_type c;
      gap = 0;
      while (gap < MAX_RUN && $urandom_range(99) < send_idle_pct) gap++;
      @(negedge clock);
      while (gap > 0) begin
         req_tvalid <= 1'b0;
         gap--;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      do @(posedge clock); while (!req_tready);
      c = predict_drive(word);
      pending_cmds.push_back(typed ? want : c);
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_cmds.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input reg_idx_type idx, input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      case (idx)
         REG_GAIN_P:     drive_cfg.gain_p     = val;
         REG_GAIN_I:     drive_cfg.gain_i     = val;
         REG_GAIN_D:     drive_cfg.gain_d     = val;
         REG_GAIN_R:     drive_cfg.gain_r     = val;
         REG_BASE_RIGHT: drive_cfg.base_right = val[SPEED_W-1:0];
         REG_BASE_LEFT:  drive_cfg.base_left  = val[SPEED_W-1:0];
         REG_MAX_RIGHT:  drive_cfg.max_right  = val[SPEED_W-1:0];
         REG_MAX_LEFT:   drive_cfg.max_left   = val[SPEED_W-1:0];
         default: ;
      endcase
   endtask

   task automatic program_phase(input int phase);
      logic [CSR_DATA_W-1:0] vals [8];
      for (int i = 0; i < 8; i++) begin
         if (i <= int'(REG_GAIN_R)) begin
            case (phase)
               1:       vals[i] = '0;
               2:       vals[i] = '1;
               4:       vals[i] = (i == int'(REG_GAIN_R)) ? '1 : 24'($urandom_range(4095));
               5:       vals[i] = 24'($urandom_range(24'hFFFFFF));
               7:       vals[i] = (i == 0) ? GAIN_P_RST : (i == 1) ? GAIN_I_RST :
                                  (i == 2) ? GAIN_D_RST : GAIN_R_RST;
               default: vals[i] = 24'($urandom_range(24'h0FFFFF));
            endcase
         end else begin
            case (phase)
               1:       vals[i] = '0;
               2, 4:    vals[i] = 24'hFF;
               7:       vals[i] = (i >= int'(REG_MAX_RIGHT)) ? MAX_RST : BASE_RST;
               default: vals[i] = 24'($urandom_range(255));
            endcase
            // Bits above the register width must be dropped by the block.
            vals[i][CSR_DATA_W-1:SPEED_W] = 16'($urandom);
         end
      end
      for (int i = 0; i < 8; i++) write_reg(reg_idx_type'(i), vals[i]);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   always @(negedge clock) begin
      if (stall_run < MAX_RUN && $urandom_range(99) < recv_stall_pct) begin
         rsp_tready <= 1'b0;
         stall_run++;
      end else begin
         rsp_tready <= 1'b1;
         stall_run = 0;
      end
   end

   always @(posedge clock) begin
      drive_cmd_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_cmds.size() == 0) begin
            report_error($sformatf("response word with nothing expected: %h", rsp_tdata));
         end else begin
            want = pending_cmds.pop_front();
            check_field("drive_valid", rsp_tuser[0], want.drive_valid);
            check_field("right_magnitude", rsp_tdata[15:0], want.right_mag);
            check_field("right_forward", rsp_tdata[16], want.right_fwd);
            check_field("left_magnitude", rsp_tdata[32:17], want.left_mag);
            check_field("left_forward", rsp_tdata[33], want.left_fwd);
            check_field("last_side", rsp_tdata[34], want.last_side);
            check_field("idle_count", rsp_tdata[42:35], want.idle_count);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      drive_cfg = '{GAIN_P_RST, GAIN_I_RST, GAIN_D_RST, GAIN_R_RST,
                    BASE_RST, BASE_RST, MAX_RST, MAX_RST};
      for (int k = 0; k < TAPS; k++) err_hist[k] = '0;
      prev_err     = '0;
      side_seen    = 1'b0;
      lost_samples = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_sample(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].want);

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         if (phase != 0) begin
            drain();
            program_phase(phase);
         end
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
            default: begin send_idle_pct = 36; recv_stall_pct = 36; end
         endcase
         // One long dropout drives the lost-line count into saturation.
         if (phase == 3)
            for (int n = 0; n < LOST_RUN; n++) send_sample(8'h00, 1'b0, '0);
         for (int n = 0; n < PHASE_ITEMS; n++) send_sample(next_sample(), 1'b0, '0);
      end

      drain();
      if (pending_cmds.size() != 0)
         report_error($sformatf("%0d responses never arrived", pending_cmds.size()));
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
